FILE: rtl/recursive_impedance_inversion_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the recursive impedance inversion block
// Shared concurrent-check helpers, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_IMPEDANCE_INVERSION_DEFINES_SVH
`define RECURSIVE_IMPEDANCE_INVERSION_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define RII_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define RII_ASSERT_NEXT(lbl, ante, cons, msg) \
  `RII_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: rtl/rii_pkg.sv
// ----------------------------------------------------------------------------
// Recursive impedance inversion package
// Widths, fixed-point constants and the work item passed from front to back.
// ----------------------------------------------------------------------------
package rii_pkg;

  localparam int REFL_W   = 16;
  localparam int IMP_W    = 32;
  localparam int FACTOR_W = 16;
  localparam int PROD_W   = IMP_W + FACTOR_W;

  // 0.999 in Q1.15, rounded to nearest.
  localparam int REFL_BOUND = 32735;
  localparam int Q15_ONE    = 32768;

  localparam int DEFAULT_QUEUE_DEPTH = 2;

  typedef logic signed [REFL_W-1:0] refl_t;
  typedef logic [IMP_W-1:0]         imp_t;
  typedef logic [FACTOR_W-1:0]      factor_t;

  // One classified sample: numerator and denominator of the step factor and
  // the already-clipped start value.
  typedef struct packed {
    logic    first;
    factor_t num;
    factor_t den;
    imp_t    start;
  } work_t;

endpackage

FILE: rtl/rii_in_if.sv
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one reflection sample per request.
// ----------------------------------------------------------------------------
interface rii_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] reflection;
  logic               first_of_trace;
  logic signed [31:0] start_impedance;

  modport source (output valid, reflection, first_of_trace, start_impedance,
                  input ready);
  modport sink   (input valid, reflection, first_of_trace, start_impedance,
                  output ready);
endinterface

FILE: rtl/rii_out_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one impedance value per request.
// ----------------------------------------------------------------------------
interface rii_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] impedance;
  logic        saturated;

  modport source (output valid, impedance, saturated, input ready);
  modport sink   (input valid, impedance, saturated, output ready);
endinterface

FILE: rtl/recursive_impedance_inversion.sv
// ----------------------------------------------------------------------------
// Recursive impedance inversion
// Turns a stream of reflection samples into a running acoustic impedance.
// ----------------------------------------------------------------------------
// Usage: each request on in_chan carries one Q1.15 reflection sample, a
// first-of-trace mark and a Q20.12 start value. Each request on out_chan
// carries the running Q20.12 impedance after that sample and a flag that
// tells whether the value was clipped at its maximum. Exactly one result
// leaves for every sample taken, in order.
// Flow: the back end takes one sample at a time through one load, one
// multiply, one range check, 32 divider steps and one write-back; when the
// product saturates it skips the divider steps. The 32-step radix-2 divider
// sets the sustained rate, and the back end takes no new sample until it has
// written back the last one.
// The front end and the queue keep taking samples while the back end works.
// Reset (rst_n low, synchronous) empties the queue and the output register
// and clears the running impedance to zero.
// When the receiver stalls, the finished result is held on out_chan and the
// back end waits before writing back; the queue then fills and in_chan
// drops ready.
// ----------------------------------------------------------------------------
module recursive_impedance_inversion
  import rii_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  rii_in_if.sink    in_chan,
  rii_out_if.source out_chan
);

  // Front to queue.
  logic  push_valid;
  logic  push_ready;
  work_t push_data;

  // Queue to back end.
  logic  pop_valid;
  logic  pop_ready;
  work_t pop_data;

  // The front end clamps the reflection and forms 1+r and 1-r in Q1.15.
  rii_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // The queue lets the front end run ahead of the long divider.
  rii_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // The back end holds the running impedance and computes the rounded
  // quotient Z * num / den, saturating when it does not fit in 32 bits.
  rii_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_chan  (out_chan)
  );

endmodule

FILE: rtl/rii_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts samples, clamps the reflection and forms the step factor terms.
// ----------------------------------------------------------------------------
module rii_front
  import rii_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rii_in_if.sink    in_chan,
  output logic      push_valid,
  output work_t     push_data,
  input  logic      push_ready
);

  localparam logic signed [REFL_W+1:0] ONE_S   = (REFL_W+2)'(Q15_ONE);
  localparam logic signed [REFL_W+1:0] BOUND_S = (REFL_W+2)'(REFL_BOUND);

  logic                     f_valid_r;
  work_t                    f_work_r;
  logic signed [REFL_W+1:0] refl_x;
  logic signed [REFL_W+1:0] refl_c;
  logic signed [REFL_W+1:0] num_w;
  logic signed [REFL_W+1:0] den_w;
  work_t                    work_nxt;
  logic                     accept;

  always_comb begin
    refl_x = (REFL_W+2)'(in_chan.reflection);
    if (refl_x > BOUND_S) begin
      refl_c = BOUND_S;
    end else if (refl_x < -BOUND_S) begin
      refl_c = -BOUND_S;
    end else begin
      refl_c = refl_x;
    end
    num_w          = ONE_S + refl_c;
    den_w          = ONE_S - refl_c;
    work_nxt.first = in_chan.first_of_trace;
    work_nxt.num   = num_w[FACTOR_W-1:0];
    work_nxt.den   = den_w[FACTOR_W-1:0];
    work_nxt.start = in_chan.start_impedance[IMP_W-1] ? '0 : imp_t'(in_chan.start_impedance);
  end

  assign in_chan.ready = !f_valid_r || push_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push_valid    = f_valid_r;
  assign push_data     = f_work_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (push_ready) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_work_r <= work_nxt;
    end
  end

endmodule

FILE: rtl/rii_queue.sv
// ----------------------------------------------------------------------------
// Work queue
// Small flip-flop FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "recursive_impedance_inversion_defines.svh"

module rii_queue
  import rii_pkg::*;
#(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  input  work_t push_data,
  output logic  push_ready,
  output logic  pop_valid,
  output work_t pop_data,
  input  logic  pop_ready
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  work_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push_fire;
  logic          pop_fire;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `RII_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "queue count beyond depth")
  `RII_ASSERT_NEXT(a_count_up, push_fire && !pop_fire, count_r == $past(count_r) + 1'b1, "queue count missed a push")
  `RII_ASSERT_NEXT(a_count_down, pop_fire && !push_fire, count_r == $past(count_r) - 1'b1, "queue count missed a pop")

endmodule

FILE: rtl/rii_back.sv
// ----------------------------------------------------------------------------
// Back end
// Applies the step factor to the running impedance with a radix-2 divider.
// ----------------------------------------------------------------------------
`include "recursive_impedance_inversion_defines.svh"

module rii_back
  import rii_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  input  work_t     pop_data,
  output logic      pop_ready,
  rii_out_if.source out_chan
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam int CNT_W = $clog2(IMP_W);

  logic [2:0]        state_r;
  work_t             work_r;
  imp_t              z_r;
  logic [PROD_W-1:0] dvd_r;
  factor_t           rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              sat_r;
  logic              out_valid_r;
  imp_t              out_imp_r;
  logic              out_sat_r;

  imp_t              z_sel;
  logic [PROD_W-1:0] prod;
  logic [FACTOR_W:0] rem_shift;
  logic              q_bit;
  logic              slot_free;

  assign z_sel     = work_r.first ? work_r.start : z_r;
  assign prod      = z_sel * work_r.num;
  assign rem_shift = {rem_r, dvd_r[IMP_W-1]};
  assign q_bit     = rem_shift >= {1'b0, work_r.den};
  assign slot_free = !out_valid_r || out_chan.ready;
  assign pop_ready = state_r == S_IDLE;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.impedance = out_imp_r;
  assign out_chan.saturated = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      z_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          state_r <= (dvd_r[PROD_W-1:IMP_W] >= work_r.den) ? S_FIN : S_DIV;
        end
        S_DIV: begin
          if (cnt_r == CNT_W'(IMP_W - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            z_r     <= dvd_r[IMP_W-1:0];
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: dividend and quotient share dvd_r, the remainder is in rem_r; the quotient bits
  // shift in at the bottom as the dividend bits shift out at the top.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          work_r <= pop_data;
        end
      end
      S_MUL: begin
        dvd_r <= prod + PROD_W'(work_r.den[FACTOR_W-1:1]);
      end
      S_CHK: begin
        cnt_r <= '0;
        rem_r <= dvd_r[PROD_W-1:IMP_W];
        if (dvd_r[PROD_W-1:IMP_W] >= work_r.den) begin
          dvd_r[IMP_W-1:0] <= '1;
          sat_r            <= 1'b1;
        end else begin
          sat_r <= 1'b0;
        end
      end
      S_DIV: begin
        cnt_r            <= cnt_r + 1'b1;
        rem_r            <= q_bit ? FACTOR_W'(rem_shift - {1'b0, work_r.den})
                                  : rem_shift[FACTOR_W-1:0];
        dvd_r[IMP_W-1:0] <= {dvd_r[IMP_W-2:0], q_bit};
      end
      S_FIN: begin
        if (slot_free) begin
          out_imp_r <= dvd_r[IMP_W-1:0];
          out_sat_r <= sat_r;
        end
      end
      default: begin
      end
    endcase
  end

  `RII_ASSERT(a_sat_clips, (out_valid_r && out_sat_r) |-> (out_imp_r == '1), "saturated result not clipped")
  `RII_ASSERT(a_rem_small, (state_r == S_DIV) |-> (rem_r < work_r.den), "divider remainder out of range")
  `RII_ASSERT_NEXT(a_fin_hold, state_r == S_FIN && !slot_free, state_r == S_FIN, "result lost while output stalled")

endmodule
